/* design/assert_macros.svh */
// assert_macros.svh: shared assertion macros for the keyed list table.
// Define NO_ASSERTIONS to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/klt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_pkg
// Shared constants, codes and types of the keyed list table.
// ----------------------------------------------------------------------------
package klt_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_LIST   = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } op_type;

   typedef struct packed {
      logic [63:0]        name_a;
      logic [63:0]        name_b;
      logic [63:0]        name_c;
      logic [47:0]        name_d;
      logic [63:0]        kind_a;
      logic [63:0]        kind_b;
      logic [31:0]        kind_c;
      logic signed [31:0] amount;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic [CNT_W-1:0]  count;
      entry_type         data;
   } cell_ctl_type;

endpackage

/* design/klt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_cell
// One list slot: holds an entry, compares its name with the request name
// and loads, shifts down or rotates as the broadcast command says.
// ----------------------------------------------------------------------------
module klt_cell (
   input  logic                     clock,
   input  klt_pkg::cell_ctl_type    ctl,
   input  logic [klt_pkg::CNT_W-1:0] idx,
   input  klt_pkg::entry_type       next_entry,
   input  klt_pkg::entry_type       head_entry,
   input  logic                     prefix_in,
   output klt_pkg::entry_type       entry,
   output logic                     prefix_out
);

   klt_pkg::entry_type entry_ff;
   klt_pkg::entry_type entry_in;
   logic               in_use;
   logic               match;

   always_comb begin
      in_use = idx < ctl.count;
      match  = in_use
               && entry_ff.name_a == ctl.data.name_a
               && entry_ff.name_b == ctl.data.name_b
               && entry_ff.name_c == ctl.data.name_c
               && entry_ff.name_d == ctl.data.name_d;
      prefix_out = prefix_in | match;

      entry_in = entry_ff;
      unique case (ctl.op)
         klt_pkg::OP_INSERT: begin
            if (idx == ctl.count) begin
               entry_in = ctl.data;
            end
         end
         klt_pkg::OP_REMOVE: begin
            if (prefix_out) begin
               entry_in = next_entry;
            end
         end
         klt_pkg::OP_ROTATE: begin
            if ((idx + klt_pkg::CNT_W'(1)) == ctl.count) begin
               entry_in = head_entry;
            end else begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* design/klt_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_chain
// Row of list cells with neighbor links, the head feedback used for rotation
// and the first-match chain used by search and remove.
// ----------------------------------------------------------------------------
module klt_chain (
   input  logic                  clock,
   input  klt_pkg::cell_ctl_type ctl,
   output klt_pkg::entry_type    head_entry,
   output logic                  hit
);

   klt_pkg::entry_type entries [klt_pkg::CAPACITY];
   logic [klt_pkg::CAPACITY:0] prefix;

   assign prefix[0]  = 1'b0;
   assign head_entry = entries[0];
   assign hit        = prefix[klt_pkg::CAPACITY];

   for (genvar i = 0; i < klt_pkg::CAPACITY; i++) begin : g_cell
      klt_pkg::entry_type next_entry;

      if (i == klt_pkg::CAPACITY - 1) begin : g_tail
         assign next_entry = entries[0];
      end else begin : g_body
         assign next_entry = entries[i + 1];
      end

      klt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (klt_pkg::CNT_W'(i)),
         .next_entry (next_entry),
         .head_entry (entries[0]),
         .prefix_in  (prefix[i]),
         .entry      (entries[i]),
         .prefix_out (prefix[i + 1])
      );
   end

endmodule

/* design/keyed_list_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_list_table_unit
// Unsorted list of named entries with insert, search, remove and list.
//
//   Channel  Ports   Direction  Content
//   request  req_*   in         one operation word with name, type, amount
//   response rsp_*   out        one word per result, last marks the final one
//
// Insert, search and remove register the request, then every cell compares
// its name and the chain updates in ST_EXEC once the response slot is free.
// For list the chain rotates one place per emitted word, so one entry leaves
// the head cell per cycle while the response channel does not stall.
// Reset clears only the control registers; no clearing pass is needed.
// A stalled response holds the chain, and a new request is taken while the
// last response word still waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_list_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [63:0]        req_name_a,
   input  logic [63:0]        req_name_b,
   input  logic [63:0]        req_name_c,
   input  logic [47:0]        req_name_d,
   input  logic [63:0]        req_kind_a,
   input  logic [63:0]        req_kind_b,
   input  logic [31:0]        req_kind_c,
   input  logic signed [31:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_out_name_a,
   output logic [63:0]        rsp_out_name_b,
   output logic [63:0]        rsp_out_name_c,
   output logic [47:0]        rsp_out_name_d,
   output logic [63:0]        rsp_out_kind_a,
   output logic [63:0]        rsp_out_kind_b,
   output logic [31:0]        rsp_out_kind_c,
   output logic signed [31:0] rsp_out_amount,
   output logic [1:0]         rsp_status,
   output logic               rsp_last,
   output logic [4:0]         rsp_entry_count
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_LIST = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   klt_pkg::func_type           func_ff, func_in;
   klt_pkg::entry_type          req_entry_ff, req_entry_in;
   logic [klt_pkg::CNT_W-1:0]   fill_count_ff, fill_count_in;
   logic [klt_pkg::CNT_W-1:0]   list_cnt_ff, list_cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   klt_pkg::entry_type          rsp_entry_ff, rsp_entry_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic [4:0]                  rsp_count_ff, rsp_count_in;

   klt_pkg::cell_ctl_type       ctl;
   klt_pkg::entry_type          head_entry;
   logic                        hit;
   logic                        out_free;
   logic                        load_rsp;
   logic                        list_end;

   klt_chain u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .head_entry (head_entry),
      .hit        (hit)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign list_end  = (list_cnt_ff + klt_pkg::CNT_W'(1)) == fill_count_ff;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      req_entry_in  = req_entry_ff;
      fill_count_in = fill_count_ff;
      list_cnt_in   = list_cnt_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      load_rsp      = 1'b0;
      ctl.op        = klt_pkg::OP_NONE;
      ctl.count     = fill_count_ff;
      ctl.data      = req_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in             = klt_pkg::func_type'(req_func);
               req_entry_in.name_a = req_name_a;
               req_entry_in.name_b = req_name_b;
               req_entry_in.name_c = req_name_c;
               req_entry_in.name_d = req_name_d;
               req_entry_in.kind_a = req_kind_a;
               req_entry_in.kind_b = req_kind_b;
               req_entry_in.kind_c = req_kind_c;
               req_entry_in.amount = req_amount;
               state_in            = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = klt_pkg::STATUS_OK;
               load_rsp      = 1'b1;
               state_in      = ST_IDLE;
               unique case (func_ff)
                  klt_pkg::FUNC_INSERT: begin
                     if (fill_count_ff == klt_pkg::CNT_W'(klt_pkg::CAPACITY)) begin
                        rsp_status_in = klt_pkg::STATUS_FULL;
                     end else begin
                        ctl.op        = klt_pkg::OP_INSERT;
                        fill_count_in = fill_count_ff + klt_pkg::CNT_W'(1);
                     end
                  end
                  klt_pkg::FUNC_SEARCH: begin
                     if (!hit) begin
                        rsp_status_in = klt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  klt_pkg::FUNC_REMOVE: begin
                     if (hit) begin
                        ctl.op        = klt_pkg::OP_REMOVE;
                        fill_count_in = fill_count_ff - klt_pkg::CNT_W'(1);
                     end else begin
                        rsp_status_in = klt_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  klt_pkg::FUNC_LIST: begin
                     if (fill_count_ff == '0) begin
                        rsp_status_in = klt_pkg::STATUS_EMPTY;
                     end else begin
                        load_rsp    = 1'b0;
                        list_cnt_in = '0;
                        state_in    = ST_LIST;
                     end
                  end
                  default: begin
                     rsp_status_in = klt_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_entry_in  = head_entry;
               rsp_status_in = klt_pkg::STATUS_OK;
               rsp_last_in   = list_end;
               load_rsp      = 1'b1;
               ctl.op        = klt_pkg::OP_ROTATE;
               list_cnt_in   = list_cnt_ff + klt_pkg::CNT_W'(1);
               if (list_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = load_rsp ? 5'(fill_count_in) : rsp_count_ff;
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_count_ff <= '0;
         list_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         list_cnt_ff   <= list_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      req_entry_ff  <= req_entry_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_name_a  = rsp_entry_ff.name_a;
   assign rsp_out_name_b  = rsp_entry_ff.name_b;
   assign rsp_out_name_c  = rsp_entry_ff.name_c;
   assign rsp_out_name_d  = rsp_entry_ff.name_d;
   assign rsp_out_kind_a  = rsp_entry_ff.kind_a;
   assign rsp_out_kind_b  = rsp_entry_ff.kind_b;
   assign rsp_out_kind_c  = rsp_entry_ff.kind_c;
   assign rsp_out_amount  = rsp_entry_ff.amount;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
                 fill_count_ff <= klt_pkg::CNT_W'(klt_pkg::CAPACITY))
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `ASSERT_IMPLY(a_list_nonempty, clock, reset, state_ff == ST_LIST, fill_count_ff != '0)
   `ASSERT_IMPLY(a_list_index, clock, reset, state_ff == ST_LIST, list_cnt_ff < fill_count_ff)

endmodule

/* test/tb_keyed_list_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_list_table_unit
// Self-checking bench for the keyed list table. A short directed table walks
// the empty, full, duplicate-name and extreme-value cases, then random
// operations run with random gaps on both channels. Every response word is
// compared field by field with a bench list copy or a hand-written answer.
// ----------------------------------------------------------------------------
module tb_keyed_list_table_unit;

   localparam int RANDOM_ITEMS = 330;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam int POOL_SIZE    = 8;

   typedef struct packed {
      klt_pkg::func_type   func;
      klt_pkg::entry_type  entry;
      logic                typed;
      logic [1:0]          typed_status;
      logic [4:0]          typed_count;
   } request_row_type;

   typedef struct packed {
      klt_pkg::entry_type  entry;
      logic [1:0]          status;
      logic                last;
      logic [4:0]          count;
   } list_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   request_row_type    req_item;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [63:0]        rsp_out_name_a;
   logic [63:0]        rsp_out_name_b;
   logic [63:0]        rsp_out_name_c;
   logic [47:0]        rsp_out_name_d;
   logic [63:0]        rsp_out_kind_a;
   logic [63:0]        rsp_out_kind_b;
   logic [31:0]        rsp_out_kind_c;
   logic signed [31:0] rsp_out_amount;
   logic [1:0]         rsp_status;
   logic               rsp_last;
   logic [4:0]         rsp_entry_count;

   klt_pkg::entry_type table_entries [klt_pkg::CAPACITY];
   int unsigned        table_fill;
   list_word_type      awaited_words [$];
   logic [239:0]       name_pool [POOL_SIZE];

   int error_count;
   int req_total;
   int rsp_total;
   int listed_words;
   int full_refusals;
   int name_misses;
   int idle_cycles;
   int quiet_left;

   keyed_list_table_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_item.func),
      .req_name_a      (req_item.entry.name_a),
      .req_name_b      (req_item.entry.name_b),
      .req_name_c      (req_item.entry.name_c),
      .req_name_d      (req_item.entry.name_d),
      .req_kind_a      (req_item.entry.kind_a),
      .req_kind_b      (req_item.entry.kind_b),
      .req_kind_c      (req_item.entry.kind_c),
      .req_amount      (req_item.entry.amount),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_name_a  (rsp_out_name_a),
      .rsp_out_name_b  (rsp_out_name_b),
      .rsp_out_name_c  (rsp_out_name_c),
      .rsp_out_name_d  (rsp_out_name_d),
      .rsp_out_kind_a  (rsp_out_kind_a),
      .rsp_out_kind_b  (rsp_out_kind_b),
      .rsp_out_kind_c  (rsp_out_kind_c),
      .rsp_out_amount  (rsp_out_amount),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [239:0] random_wide();
      logic [255:0] bits;
      for (int i = 0; i < 8; i++) begin
         bits[i*32 +: 32] = $urandom;
      end
      return bits[239:0];
   endfunction

   // Printable name of random length, zero padded up to 30 bytes.
   function automatic logic [239:0] text_name();
      logic [239:0] key;
      int unsigned  len;
      key = '0;
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
         key[i*8 +: 8] = 8'($urandom_range(32, 126));
      end
      return key;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic request_row_type make_row(input klt_pkg::func_type fn,
         input logic [239:0] key, input logic [159:0] kind, input logic [31:0] amt,
         input logic typed, input logic [1:0] status, input logic [4:0] count);
      request_row_type row;
      row.func = fn;
      {row.entry.name_d, row.entry.name_c, row.entry.name_b, row.entry.name_a} = key;
      {row.entry.kind_c, row.entry.kind_b, row.entry.kind_a} = kind;
      row.entry.amount = amt;
      row.typed = typed;
      row.typed_status = status;
      row.typed_count = count;
      return row;
   endfunction

   // Updates the bench copy of the list and queues the words the block owes.
   function automatic void apply_operation(input request_row_type item);
      list_word_type word;
      int            hit;
      hit = -1;
      word = '0;
      word.last = 1'b1;
      for (int i = 0; i < table_fill; i++) begin
         if (hit < 0 && {table_entries[i].name_a, table_entries[i].name_b,
               table_entries[i].name_c, table_entries[i].name_d} ==
               {item.entry.name_a, item.entry.name_b, item.entry.name_c,
               item.entry.name_d}) begin
            hit = i;
         end
      end
      case (item.func)
         klt_pkg::FUNC_INSERT: begin
            if (table_fill == klt_pkg::CAPACITY) begin
               word.status = klt_pkg::STATUS_FULL;
               full_refusals++;
            end else begin
               table_entries[table_fill] = item.entry;
               table_fill++;
               word.status = klt_pkg::STATUS_OK;
            end
         end
         klt_pkg::FUNC_SEARCH: begin
            word.status = (hit < 0) ? klt_pkg::STATUS_NOT_FOUND : klt_pkg::STATUS_OK;
            if (hit < 0) name_misses++;
         end
         klt_pkg::FUNC_REMOVE: begin
            if (hit < 0) begin
               word.status = klt_pkg::STATUS_NOT_FOUND;
               name_misses++;
            end else begin
               for (int i = hit; i + 1 < table_fill; i++) begin
                  table_entries[i] = table_entries[i + 1];
               end
               table_fill--;
               word.status = klt_pkg::STATUS_OK;
            end
         end
         default: begin
            if (table_fill == 0) begin
               word.status = klt_pkg::STATUS_EMPTY;
            end else begin
               for (int i = 0; i < table_fill; i++) begin
                  word.entry = table_entries[i];
                  word.status = klt_pkg::STATUS_OK;
                  word.last = (i + 1 == table_fill);
                  word.count = table_fill[4:0];
                  awaited_words.push_back(word);
                  listed_words++;
               end
               return;
            end
         end
      endcase
      word.count = table_fill[4:0];
      awaited_words.push_back(word);
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
         input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         error_count++;
      end
   endfunction

   function automatic request_row_type random_row();
      logic [239:0]      key;
      logic [31:0]       amt;
      klt_pkg::func_type fn;
      int unsigned       roll;
      roll = $urandom_range(0, 99);
      if (table_fill < 3 && roll < 60) roll = 0;
      if (roll < 38) fn = klt_pkg::FUNC_INSERT;
      else if (roll < 58) fn = klt_pkg::FUNC_SEARCH;
      else if (roll < 86) fn = klt_pkg::FUNC_REMOVE;
      else fn = klt_pkg::FUNC_LIST;
      roll = $urandom_range(0, 99);
      if (roll < 45 && table_fill != 0) begin
         roll = $urandom_range(0, table_fill - 1);
         key = {table_entries[roll].name_d, table_entries[roll].name_c,
               table_entries[roll].name_b, table_entries[roll].name_a};
         if ($urandom_range(0, 9) == 0) key[$urandom_range(0, 239)] ^= 1'b1;
      end else if (roll < 75) begin
         key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (roll < 90) begin
         key = text_name();
      end else begin
         key = random_wide();
      end
      roll = $urandom_range(0, 9);
      if (roll == 0) amt = 32'h8000_0000;
      else if (roll == 1) amt = 32'h7fff_ffff;
      else amt = $urandom;
      return make_row(fn, key, 160'(random_wide()), amt, 1'b0, klt_pkg::STATUS_OK, 5'd0);
   endfunction

   task automatic send_row(input request_row_type row);
      int unsigned gap;
      gap = (quiet_left != 0) ? 0 : pick_gap();
      if (quiet_left != 0) quiet_left--;
      else if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(15, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= row;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : word_checker
      list_word_type want;
      list_word_type fixed;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_total++;
            if (awaited_words.size() == 0) begin
               $error("response word arrived with nothing outstanding");
               error_count++;
            end else begin
               want = awaited_words.pop_front();
               check_field("out_name_a", want.entry.name_a, rsp_out_name_a);
               check_field("out_name_b", want.entry.name_b, rsp_out_name_b);
               check_field("out_name_c", want.entry.name_c, rsp_out_name_c);
               check_field("out_name_d", 64'(want.entry.name_d), 64'(rsp_out_name_d));
               check_field("out_kind_a", want.entry.kind_a, rsp_out_kind_a);
               check_field("out_kind_b", want.entry.kind_b, rsp_out_kind_b);
               check_field("out_kind_c", 64'(want.entry.kind_c), 64'(rsp_out_kind_c));
               check_field("out_amount", {32'd0, want.entry.amount},
                     {32'd0, rsp_out_amount});
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("last", 64'(want.last), 64'(rsp_last));
               check_field("entry_count", 64'(want.count), 64'(rsp_entry_count));
            end
         end
         if (req_valid && req_ready) begin
            req_total++;
            apply_operation(req_item);
            // Rows with a hand-written answer replace the computed word.
            if (req_item.typed) begin
               fixed = '0;
               fixed.status = req_item.typed_status;
               fixed.last = 1'b1;
               fixed.count = req_item.typed_count;
               void'(awaited_words.pop_back());
               awaited_words.push_back(fixed);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : rsp_stalls
      int unsigned hold;
      int unsigned stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) hold = $urandom_range(30, 80);
         else hold = $urandom_range(1, 6);
         rsp_ready <= 1'b1;
         repeat (hold) @(negedge clock);
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      request_row_type directed_rows [$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      table_fill = 0;
      error_count = 0;
      req_total = 0;
      rsp_total = 0;
      listed_words = 0;
      full_refusals = 0;
      name_misses = 0;
      idle_cycles = 0;
      quiet_left = 0;
      for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = text_name();

      directed_rows.push_back(make_row(klt_pkg::FUNC_LIST, '0, '0, '0, 1'b1,
            klt_pkg::STATUS_EMPTY, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_SEARCH, '1, '0, '0, 1'b1,
            klt_pkg::STATUS_NOT_FOUND, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_REMOVE, '0, '1, '1, 1'b1,
            klt_pkg::STATUS_NOT_FOUND, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_INSERT, '1, '1, 32'h7fff_ffff, 1'b1,
            klt_pkg::STATUS_OK, 5'd1));
      directed_rows.push_back(make_row(klt_pkg::FUNC_INSERT, '0, '0, 32'h8000_0000, 1'b1,
            klt_pkg::STATUS_OK, 5'd2));
      directed_rows.push_back(make_row(klt_pkg::FUNC_INSERT, '1, 160'(random_wide()),
            32'hffff_ffff, 1'b1, klt_pkg::STATUS_OK, 5'd3));
      for (int i = 3; i < klt_pkg::CAPACITY; i++) begin
         directed_rows.push_back(make_row(klt_pkg::FUNC_INSERT, text_name(),
               160'(random_wide()), $urandom, 1'b0, klt_pkg::STATUS_OK, 5'd0));
      end
      directed_rows.push_back(make_row(klt_pkg::FUNC_INSERT, text_name(),
            160'(random_wide()), $urandom, 1'b1, klt_pkg::STATUS_FULL,
            5'(klt_pkg::CAPACITY)));
      directed_rows.push_back(make_row(klt_pkg::FUNC_LIST, '0, '0, '0, 1'b0,
            klt_pkg::STATUS_OK, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_SEARCH, '1, '0, '0, 1'b0,
            klt_pkg::STATUS_OK, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_REMOVE, '1, '0, '0, 1'b0,
            klt_pkg::STATUS_OK, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_REMOVE, '0, '0, '0, 1'b0,
            klt_pkg::STATUS_OK, 5'd0));
      directed_rows.push_back(make_row(klt_pkg::FUNC_LIST, '1, '1, '1, 1'b0,
            klt_pkg::STATUS_OK, 5'd0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);
      repeat (RANDOM_ITEMS) send_row(random_row());
      req_valid <= 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d operations (%0d directed) and checked %0d response words,",
            req_total, directed_rows.size(), rsp_total);
      $display("including %0d listed entries, %0d full refusals and %0d name misses.",
            listed_words, full_refusals, name_misses);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
